/* rtl/sbcr_pkg.sv */
// ----------------------------------------------------------------------------
// Spectrum bar column renderer package
// Shared constants, field layout, register indexes and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbcr_pkg;

    localparam int DEF_COLUMNS       = 64;
    localparam int DEF_ROWS          = 16;
    localparam int DEF_HISTORY_DEPTH = 16;

    localparam int COL_W    = 6;
    localparam int MAG_W    = 31;
    localparam int COLOR_W  = 8;
    localparam int PIXROW_W = 4;
    localparam int THRESH_W = 8;
    localparam int MODE_W   = 2;
    localparam int DECAY_W  = 16;
    localparam int FRAC_W   = 15;

    localparam int IN_COL_LSB = 0;
    localparam int IN_MAG_LSB = IN_COL_LSB + COL_W;
    localparam int IN_MR_LSB  = IN_MAG_LSB + MAG_W;
    localparam int IN_MG_LSB  = IN_MR_LSB + COLOR_W;
    localparam int IN_MB_LSB  = IN_MG_LSB + COLOR_W;
    localparam int IN_PR_LSB  = IN_MB_LSB + COLOR_W;
    localparam int IN_PG_LSB  = IN_PR_LSB + COLOR_W;
    localparam int IN_PB_LSB  = IN_PG_LSB + COLOR_W;
    localparam int IN_USED_W  = IN_PB_LSB + COLOR_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    localparam int OUT_USED_W  = COL_W + PIXROW_W + 3 * COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLAMP_LEVEL     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_MODE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_FACTOR    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_SIZE       = 3'd4;

    localparam logic [MODE_W-1:0] MODE_LOG  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SQRT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIN  = 2'd2;

    localparam logic [MAG_W-1:0]    RST_CLAMP_LEVEL     = 31'd330301440;
    localparam logic [THRESH_W-1:0] RST_LOWER_THRESHOLD = 8'd238;
    localparam logic [MODE_W-1:0]   RST_SCALE_MODE      = MODE_LIN;
    localparam logic [DECAY_W-1:0]  RST_DECAY_FACTOR    = 16'd29000;
    localparam logic [MAG_W-1:0]    RST_STEP_SIZE       = 31'd21500000;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic row_step;
        logic peak_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic rows_last;
        logic peak_pending;
        logic out_free;
    } t_status;

endpackage

/* rtl/sbcr_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_we,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sbcr_ctrl.sv */
// ----------------------------------------------------------------------------
// Spectrum bar column renderer controller
// Sequences history clearing, history scan, row rendering and the peak pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    output logic              o_in_tready,
    input  sbcr_pkg::t_status i_status,
    output sbcr_pkg::t_cmd    o_cmd
);
    import sbcr_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_ROWS  = 3'd3;
    localparam logic [2:0] ST_PEAK  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (i_status.out_free) begin
                    o_cmd.row_step = 1'b1;
                    if (i_status.rows_last) begin
                        if (i_status.peak_pending) begin
                            n_state = ST_PEAK;
                        end else begin
                            o_cmd.finish = 1'b1;
                            n_state      = ST_IDLE;
                        end
                    end
                end
            end
            ST_PEAK: begin
                if (i_status.out_free) begin
                    o_cmd.peak_step = 1'b1;
                    o_cmd.finish    = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/sbcr_datapath.sv */
// ----------------------------------------------------------------------------
// Spectrum bar column renderer datapath
// Configuration registers, history RAM, level decay and pixel output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_datapath #(
    parameter int COLUMNS       = sbcr_pkg::DEF_COLUMNS,
    parameter int ROWS          = sbcr_pkg::DEF_ROWS,
    parameter int HISTORY_DEPTH = sbcr_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sbcr_pkg::t_cmd                     i_cmd,
    output sbcr_pkg::t_status                  o_status,
    input  logic [sbcr_pkg::IN_TDATA_W-1:0]    i_in_tdata,
    input  logic                               i_in_tlast,
    input  logic                               i_cfg_valid,
    input  logic [sbcr_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sbcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_out_tready,
    output logic                               o_out_tvalid,
    output logic [sbcr_pkg::OUT_TDATA_W-1:0]   o_out_tdata,
    output logic                               o_out_tlast
);
    import sbcr_pkg::*;

    localparam int RW        = $clog2(ROWS);
    localparam int CW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int SW        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SIW       = $clog2(HISTORY_DEPTH + 1);
    localparam int MEM_DEPTH = COLUMNS * HISTORY_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SUB_W     = MAG_W + $clog2(ROWS + 2);
    localparam int REM_W     = COL_W + 9;

    function automatic logic [CW-1:0] col_mod(input logic [COL_W-1:0] c);
        logic [REM_W-1:0] rem;
        rem = REM_W'(c);
        for (int k = COL_W - 1; k >= 0; k--) begin
            if (rem >= (REM_W'(COLUMNS) << k)) begin
                rem = rem - (REM_W'(COLUMNS) << k);
            end
        end
        return rem[CW-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] dim_chan(input logic [COLOR_W-1:0] c,
                                                    input logic [15:0] lvl);
        return (16'(c) < lvl) ? c : lvl[COLOR_W-1:0];
    endfunction

    logic [MAG_W-1:0]    r_cfg_clamp;
    logic [THRESH_W-1:0] r_cfg_thresh;
    logic [MODE_W-1:0]   r_cfg_mode;
    logic [DECAY_W-1:0]  r_cfg_decay;
    logic [MAG_W-1:0]    r_cfg_step;

    logic [AW-1:0]  r_clr_addr;
    logic [SIW-1:0] r_scan_idx;
    logic           r_rd_pend;
    logic [SW-1:0]  r_slot;
    logic [SW-1:0]  n_slot;
    logic [RW-1:0]  r_maxy;
    logic [RW-1:0]  r_row;

    logic [AW-1:0]      r_base;
    logic [MAG_W-1:0]   r_sample;
    logic [MAG_W-1:0]   n_sample;
    logic [SUB_W-1:0]   r_subtract;
    logic [SUB_W-1:0]   n_subtract;
    logic [COL_W-1:0]   r_col;
    logic [COLOR_W-1:0] r_mr, r_mg, r_mb, r_pr, r_pg, r_pb;
    logic               r_frame_end;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    logic [COL_W-1:0] w_in_col;
    logic [MAG_W-1:0] w_in_mag;
    logic [MAG_W-1:0] w_thresh;
    logic             w_lit;
    logic             w_dim;
    logic             w_under;
    logic [46:0]      w_prod;
    logic [MAG_W-1:0] w_log_next;
    logic [SUB_W-1:0] w_samp_ext;
    logic [SUB_W-1:0] w_diff;
    logic [MAG_W-1:0] w_lin_next;
    logic [15:0]      w_lvl;
    logic [RW-1:0]    w_row_maxy;
    logic             w_rows_last;
    logic [RW-1:0]    w_top_row;
    logic [RW-1:0]    w_peak_row;
    logic [RW+3:0]    w_top_ext;
    logic [RW+3:0]    w_peak_ext;
    logic [COLOR_W-1:0] w_r, w_g, w_b;

    logic [AW-1:0]  w_mem_addr;
    logic           w_mem_we;
    logic [RW-1:0]  w_mem_wdata;
    logic [RW-1:0]  w_mem_rdata;

    assign w_in_col = i_in_tdata[IN_COL_LSB +: COL_W];
    assign w_in_mag = i_in_tdata[IN_MAG_LSB +: MAG_W];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_clamp  <= RST_CLAMP_LEVEL;
            r_cfg_thresh <= RST_LOWER_THRESHOLD;
            r_cfg_mode   <= RST_SCALE_MODE;
            r_cfg_decay  <= RST_DECAY_FACTOR;
            r_cfg_step   <= RST_STEP_SIZE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLAMP_LEVEL:     r_cfg_clamp  <= i_cfg_data[MAG_W-1:0];
                CFG_LOWER_THRESHOLD: r_cfg_thresh <= i_cfg_data[THRESH_W-1:0];
                CFG_SCALE_MODE:      r_cfg_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_DECAY_FACTOR:    r_cfg_decay  <= i_cfg_data[DECAY_W-1:0];
                CFG_STEP_SIZE:       r_cfg_step   <= i_cfg_data[MAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Row classification and level decay.
    assign w_thresh   = {{(MAG_W - THRESH_W - FRAC_W){1'b0}}, r_cfg_thresh, {FRAC_W{1'b0}}};
    assign w_lit      = r_sample > w_thresh;
    assign w_dim      = !w_lit && (r_sample != '0);
    assign w_under    = !w_lit && !w_dim && (r_row < r_maxy);
    assign w_prod     = r_sample * r_cfg_decay;
    assign w_log_next = w_prod[46] ? {MAG_W{1'b1}} : w_prod[45:FRAC_W];
    assign w_samp_ext = SUB_W'(r_sample);
    assign w_diff     = w_samp_ext - r_subtract;
    assign w_lin_next = (r_subtract >= w_samp_ext) ? MAG_W'(1) : w_diff[MAG_W-1:0];
    assign w_lvl      = r_sample[MAG_W-1:FRAC_W];
    assign w_row_maxy = (w_dim && (r_row > r_maxy)) ? r_row : r_maxy;
    assign w_rows_last = (r_row == RW'(ROWS - 1));

    always_comb begin
        n_sample   = r_sample;
        n_subtract = r_subtract;
        if (w_lit) begin
            case (r_cfg_mode)
                MODE_LOG: begin
                    n_sample = w_log_next;
                end
                MODE_SQRT: begin
                    n_sample   = w_lin_next;
                    n_subtract = r_subtract + SUB_W'(r_cfg_step);
                end
                default: begin
                    n_sample = w_lin_next;
                end
            endcase
        end else if (w_dim) begin
            n_sample = '0;
        end
    end

    always_comb begin
        w_r = '0;
        w_g = '0;
        w_b = '0;
        if (w_lit) begin
            w_r = r_mr;
            w_g = r_mg;
            w_b = r_mb;
        end else if (w_dim) begin
            w_r = dim_chan(r_mr, w_lvl);
            w_g = dim_chan(r_mg, w_lvl);
            w_b = dim_chan(r_mb, w_lvl);
        end else if (w_under) begin
            w_r = r_mr >> 3;
            w_g = r_mg >> 3;
            w_b = r_mb >> 3;
        end
    end

    assign w_top_row  = RW'(ROWS - 1) - r_row;
    assign w_peak_row = RW'(ROWS - 1) - r_maxy;
    assign w_top_ext  = {4'b0, w_top_row};
    assign w_peak_ext = {4'b0, w_peak_row};

    assign n_slot = (r_slot == SW'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    // History RAM port sharing: clearing sweep, scan reads, dim-row write.
    always_comb begin
        w_mem_addr  = r_base + AW'(r_slot);
        w_mem_we    = 1'b0;
        w_mem_wdata = r_row;
        if (i_cmd.clear) begin
            w_mem_addr  = r_clr_addr;
            w_mem_we    = 1'b1;
            w_mem_wdata = '0;
        end else if (i_cmd.scan) begin
            w_mem_addr = r_base + AW'(r_scan_idx);
        end else if (i_cmd.row_step && w_dim) begin
            w_mem_we = 1'b1;
        end
    end

    sbcr_ram #(
        .WIDTH (RW),
        .DEPTH (MEM_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_addr  (w_mem_addr),
        .i_we    (w_mem_we),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_scan_idx  <= '0;
            r_rd_pend   <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_scan_idx <= '0;
                r_rd_pend  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                r_rd_pend  <= r_scan_idx < SIW'(HISTORY_DEPTH);
            end
            if (i_cmd.finish && r_frame_end) begin
                r_slot <= n_slot;
            end
            if (i_cmd.row_step || i_cmd.peak_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-column working registers and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col       <= w_in_col;
            r_base      <= AW'(int'(col_mod(w_in_col)) * HISTORY_DEPTH);
            r_sample    <= (w_in_mag > r_cfg_clamp) ? r_cfg_clamp : w_in_mag;
            r_subtract  <= SUB_W'(r_cfg_step);
            r_mr        <= i_in_tdata[IN_MR_LSB +: COLOR_W];
            r_mg        <= i_in_tdata[IN_MG_LSB +: COLOR_W];
            r_mb        <= i_in_tdata[IN_MB_LSB +: COLOR_W];
            r_pr        <= i_in_tdata[IN_PR_LSB +: COLOR_W];
            r_pg        <= i_in_tdata[IN_PG_LSB +: COLOR_W];
            r_pb        <= i_in_tdata[IN_PB_LSB +: COLOR_W];
            r_frame_end <= i_in_tlast;
            r_row       <= '0;
            r_maxy      <= '0;
        end else if (i_cmd.scan) begin
            if (r_rd_pend && (w_mem_rdata > r_maxy)) begin
                r_maxy <= w_mem_rdata;
            end
        end else if (i_cmd.row_step) begin
            r_sample   <= n_sample;
            r_subtract <= n_subtract;
            r_maxy     <= w_row_maxy;
            r_row      <= r_row + 1'b1;
        end
        if (i_cmd.row_step) begin
            r_out_data <= OUT_TDATA_W'({w_b, w_g, w_r, w_top_ext[PIXROW_W-1:0], r_col});
            r_out_last <= w_rows_last && (w_row_maxy == '0);
        end else if (i_cmd.peak_step) begin
            r_out_data <= OUT_TDATA_W'({r_pb, r_pg, r_pr, w_peak_ext[PIXROW_W-1:0], r_col});
            r_out_last <= 1'b1;
        end
    end

    assign o_status.clear_last   = (r_clr_addr == AW'(MEM_DEPTH - 1));
    assign o_status.scan_done    = (r_scan_idx == SIW'(HISTORY_DEPTH));
    assign o_status.rows_last    = w_rows_last;
    assign o_status.peak_pending = (w_row_maxy != '0);
    assign o_status.out_free     = !r_out_valid || i_out_tready;

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = r_out_data;
    assign o_out_tlast  = r_out_last;

endmodule

/* rtl/spectrum_bar_column_renderer.sv */
// ----------------------------------------------------------------------------
// Spectrum bar column renderer
// Each column runs a single-port history scan, then one row per cycle while
// the pixel output is free, then the peak pixel when one is drawn. A new
// column is taken only once the last pixel of the previous one is in the
// output register. Reset clears the history with a sweep over all COLUMNS *
// HISTORY_DEPTH entries before the first transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectrum_bar_column_renderer #(
    parameter int COLUMNS       = sbcr_pkg::DEF_COLUMNS,
    parameter int ROWS          = sbcr_pkg::DEF_ROWS,
    parameter int HISTORY_DEPTH = sbcr_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // column, magnitude, main_red, main_green, main_blue,
    // peak_red, peak_green, peak_blue, zero pad
    input  logic [sbcr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // frame_end
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_column, pixel_row, red, green, blue, zero pad
    output logic [sbcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // last
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sbcr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [sbcr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sbcr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    sbcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sbcr_datapath #(
        .COLUMNS       (COLUMNS),
        .ROWS          (ROWS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tlast   (s_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/sbcr_checker.sv */
// ----------------------------------------------------------------------------
// Spectrum bar column renderer checker
// Port-level properties of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbcr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sbcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("Renderer active in the first cycle after reset.");

    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Second column taken while a column is in progress.");

    a_only_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("Input ready while a non-final pixel is pending.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled pixel transfer changed.");

endmodule

bind spectrum_bar_column_renderer sbcr_checker u_sbcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/spectrum_bar_column_renderer_test.sv */
// ----------------------------------------------------------------------------
// Spectrum bar column renderer testbench
// Sends spectrum columns over the input stream. Each accepted column is run
// through a bar-graph predictor with its own peak history, which yields the
// expected pixel transfers. Output pixels are checked in order against those
// expectations. Configuration changes only while the renderer is idle.
// Directed columns cover the corner cases, and randomized columns follow
// under several decay settings. Both stream sides idle at random, and the
// pixel sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectrum_bar_column_renderer_test;

    import sbcr_pkg::*;

    localparam int LIMIT  = 400000;
    localparam int SETTLE = 2 * (DEF_HISTORY_DEPTH + DEF_ROWS + 3);

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [MAG_W-1:0]  MAG_MAX    = '1;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [MAG_W-1:0]   magnitude;
        logic [COLOR_W-1:0] main_red, main_green, main_blue;
        logic [COLOR_W-1:0] peak_red, peak_green, peak_blue;
        logic               frame_end;
    } t_column;

    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [PIXROW_W-1:0] row;
        logic [COLOR_W-1:0]  red, green, blue;
        logic                last;
    } t_pixel;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // Predictor state and its copy of the registers.
    logic [MAG_W-1:0]    clamp_reg  = RST_CLAMP_LEVEL;
    logic [THRESH_W-1:0] thresh_reg = RST_LOWER_THRESHOLD;
    logic [MODE_W-1:0]   mode_reg   = RST_SCALE_MODE;
    logic [DECAY_W-1:0]  decay_reg  = RST_DECAY_FACTOR;
    logic [MAG_W-1:0]    step_reg   = RST_STEP_SIZE;
    logic [3:0]          peak_hist [DEF_COLUMNS][DEF_HISTORY_DEPTH];
    logic [3:0]          ring_slot  = '0;

    t_column pending_columns[$];
    t_pixel  expected_pixels[$];

    int  columns_queued = 0;
    int  columns_taken  = 0;
    int  pixels_seen    = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  steady         = 1'b0;
    bit  column_xfer    = 1'b0;
    bit  pixel_xfer     = 1'b0;

    spectrum_bar_column_renderer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_column(input t_column c);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[IN_COL_LSB +: COL_W]   = c.column;
        d[IN_MAG_LSB +: MAG_W]   = c.magnitude;
        d[IN_MR_LSB +: COLOR_W]  = c.main_red;
        d[IN_MG_LSB +: COLOR_W]  = c.main_green;
        d[IN_MB_LSB +: COLOR_W]  = c.main_blue;
        d[IN_PR_LSB +: COLOR_W]  = c.peak_red;
        d[IN_PG_LSB +: COLOR_W]  = c.peak_green;
        d[IN_PB_LSB +: COLOR_W]  = c.peak_blue;
        return d;
    endfunction

    // Walks one column up through the rows and queues the pixels it draws.
    function automatic void render_column(input t_column c);
        longint level, thresh, cut, prod;
        int     held, lvl;
        t_pixel px;
        t_pixel batch[$];
        level = c.magnitude;
        if (level > clamp_reg) begin
            level = clamp_reg;
        end
        thresh = longint'(thresh_reg) << FRAC_W;
        cut    = step_reg;
        held   = 0;
        for (int h = 0; h < DEF_HISTORY_DEPTH; h++) begin
            if (peak_hist[c.column][h] > held) begin
                held = peak_hist[c.column][h];
            end
        end
        for (int y = 0; y < DEF_ROWS; y++) begin
            px        = '0;
            px.column = c.column;
            px.row    = PIXROW_W'(DEF_ROWS - 1 - y);
            if (level > thresh) begin
                px.red   = c.main_red;
                px.green = c.main_green;
                px.blue  = c.main_blue;
                if (mode_reg == MODE_LOG) begin
                    prod  = (level * longint'(decay_reg)) >> FRAC_W;
                    level = (prod > longint'(MAG_MAX)) ? longint'(MAG_MAX) : prod;
                end else begin
                    level = (level - cut < 1) ? 1 : level - cut;
                    if (mode_reg == MODE_SQRT) begin
                        cut = cut + step_reg;
                    end
                end
            end else if (level > 0) begin
                lvl      = int'(level >> FRAC_W);
                px.red   = COLOR_W'((int'(c.main_red) < lvl) ? int'(c.main_red) : lvl);
                px.green = COLOR_W'((int'(c.main_green) < lvl) ? int'(c.main_green) : lvl);
                px.blue  = COLOR_W'((int'(c.main_blue) < lvl) ? int'(c.main_blue) : lvl);
                peak_hist[c.column][ring_slot] = 4'(y);
                level = 0;
                if (held < y) begin
                    held = y;
                end
            end else if (y < held) begin
                px.red   = c.main_red >> 3;
                px.green = c.main_green >> 3;
                px.blue  = c.main_blue >> 3;
            end
            batch.push_back(px);
        end
        if (held > 0) begin
            px        = '0;
            px.column = c.column;
            px.row    = PIXROW_W'(DEF_ROWS - 1 - held);
            px.red    = c.peak_red;
            px.green  = c.peak_green;
            px.blue   = c.peak_blue;
            batch.push_back(px);
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) begin
            expected_pixels.push_back(batch[i]);
        end
        if (c.frame_end) begin
            ring_slot = ring_slot + 1'b1;
        end
    endfunction

    function automatic t_column sampled_column();
        t_column c;
        c.column     = s_axis_tdata[IN_COL_LSB +: COL_W];
        c.magnitude  = s_axis_tdata[IN_MAG_LSB +: MAG_W];
        c.main_red   = s_axis_tdata[IN_MR_LSB +: COLOR_W];
        c.main_green = s_axis_tdata[IN_MG_LSB +: COLOR_W];
        c.main_blue  = s_axis_tdata[IN_MB_LSB +: COLOR_W];
        c.peak_red   = s_axis_tdata[IN_PR_LSB +: COLOR_W];
        c.peak_green = s_axis_tdata[IN_PG_LSB +: COLOR_W];
        c.peak_blue  = s_axis_tdata[IN_PB_LSB +: COLOR_W];
        c.frame_end  = s_axis_tlast;
        return c;
    endfunction

    function automatic void queue_column(input logic [COL_W-1:0] col,
                                         input logic [MAG_W-1:0] mag,
                                         input logic [23:0] main_rgb,
                                         input logic [23:0] peak_rgb,
                                         input logic fe);
        t_column c;
        c.column    = col;
        c.magnitude = mag;
        {c.main_red, c.main_green, c.main_blue} = main_rgb;
        {c.peak_red, c.peak_green, c.peak_blue} = peak_rgb;
        c.frame_end = fe;
        pending_columns.push_back(c);
        columns_queued++;
    endfunction

    // Most columns land on a few hot bins so that their peak history fills.
    function automatic void queue_random_column();
        logic [COL_W-1:0] col;
        logic [MAG_W-1:0] mag;
        col = ($urandom_range(0, 1) == 0) ? COL_W'($urandom_range(0, 3)) : COL_W'($urandom);
        case ($urandom_range(0, 7))
            0: mag = '0;
            1: mag = MAG_W'($urandom);
            2: mag = MAG_MAX;
            3: mag = MAG_W'((longint'(thresh_reg) << FRAC_W) + $urandom_range(0, 2) - 1);
            default: mag = MAG_W'($urandom_range(0, clamp_reg));
        endcase
        queue_column(col, mag, 24'($urandom), 24'($urandom), $urandom_range(0, 3) == 0);
    endfunction

    task automatic wait_idle();
        while (columns_taken != columns_queued || expected_pixels.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_CLAMP_LEVEL:     clamp_reg  = val[MAG_W-1:0];
            CFG_LOWER_THRESHOLD: thresh_reg = val[THRESH_W-1:0];
            CFG_SCALE_MODE:      mode_reg   = val[MODE_W-1:0];
            CFG_DECAY_FACTOR:    decay_reg  = val[DECAY_W-1:0];
            CFG_STEP_SIZE:       step_reg   = val[MAG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [MAG_W-1:0] clamp,
                             input logic [THRESH_W-1:0] thresh,
                             input logic [MODE_W-1:0] mode,
                             input logic [DECAY_W-1:0] decay,
                             input logic [MAG_W-1:0] step);
        wait_idle();
        write_reg(CFG_CLAMP_LEVEL, clamp);
        write_reg(CFG_LOWER_THRESHOLD, thresh);
        write_reg(CFG_SCALE_MODE, mode);
        write_reg(CFG_DECAY_FACTOR, decay);
        write_reg(CFG_STEP_SIZE, step);
    endtask

    task automatic run_random(input int count, input bit no_idle);
        steady = no_idle;
        repeat (count) queue_random_column();
    endtask

    // Column source.
    always @(negedge i_clk) begin
        t_column nxt;
        if (i_rst_n && (column_xfer || !s_axis_tvalid)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_columns.size() != 0) begin
                nxt = pending_columns.pop_front();
                s_axis_tdata  <= pack_column(nxt);
                s_axis_tlast  <= nxt.frame_end;
                s_axis_tvalid <= 1'b1;
                send_gap = steady ? 0 : $urandom_range(0, 5);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Pixel sink, with one long hold-off while columns are still waiting.
    always @(negedge i_clk) begin
        if (!hold_done && pixels_seen >= 600 && pending_columns.size() >= 8) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pixel_xfer) begin
                recv_gap = steady ? 0 : $urandom_range(0, 5);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Transfer monitor and checker.
    always @(posedge i_clk) begin
        t_pixel got, want;
        bit     have;
        column_xfer <= s_axis_tvalid && s_axis_tready;
        pixel_xfer  <= m_axis_tvalid && m_axis_tready;
        if (m_axis_tvalid && m_axis_tready) begin
            got.column = m_axis_tdata[0 +: COL_W];
            got.row    = m_axis_tdata[COL_W +: PIXROW_W];
            got.red    = m_axis_tdata[COL_W + PIXROW_W +: COLOR_W];
            got.green  = m_axis_tdata[COL_W + PIXROW_W + COLOR_W +: COLOR_W];
            got.blue   = m_axis_tdata[COL_W + PIXROW_W + 2 * COLOR_W +: COLOR_W];
            got.last   = m_axis_tlast;
            have = expected_pixels.size() != 0;
            want = have ? expected_pixels.pop_front() : 'x;
            if (!have || got !== want) begin
                if (mismatches < 10) begin
                    $display("pixel %0d: expected col %0d row %0d rgb %h %h %h last %b%s",
                             pixels_seen, want.column, want.row, want.red, want.green,
                             want.blue, want.last, have ? "" : " (none expected)");
                    $display("pixel %0d: got col %0d row %0d rgb %h %h %h last %b",
                             pixels_seen, got.column, got.row, got.red, got.green,
                             got.blue, got.last);
                end
                mismatches++;
            end
            pixels_seen++;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            render_column(sampled_column());
            columns_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < DEF_COLUMNS; c++) begin
            for (int h = 0; h < DEF_HISTORY_DEPTH; h++) begin
                peak_hist[c][h] = '0;
            end
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty column, clamped column, threshold edges.
        queue_column(0, 0, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        queue_column(63, MAG_MAX, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        queue_column(1, MAG_W'(238 << FRAC_W), 24'h80C0FF, 24'h010203, 1'b0);
        queue_column(1, MAG_W'((238 << FRAC_W) + 1), 24'h80C0FF, 24'h010203, 1'b0);
        queue_column(2, 1, 24'h000000, 24'hFFFFFF, 1'b0);
        queue_column(1, 0, 24'hFFFFFF, 24'hABCDEF, 1'b1);

        // Logarithmic decay at unity, above unity, and at zero.
        configure(MAG_MAX, 0, MODE_LOG, 16'd32768, RST_STEP_SIZE);
        queue_column(3, MAG_MAX, 24'h123456, 24'hFEDCBA, 1'b0);
        configure(MAG_MAX, 255, MODE_LOG, 16'hFFFF, RST_STEP_SIZE);
        queue_column(4, MAG_W'((255 << FRAC_W) + 1), 24'hFF00FF, 24'h00FF00, 1'b0);
        queue_column(5, MAG_MAX, 24'h7F7F7F, 24'h808080, 1'b0);
        configure(MAG_MAX, 100, MODE_LOG, 16'd0, RST_STEP_SIZE);
        queue_column(6, MAG_MAX, 24'hFFFFFF, 24'h000000, 1'b0);

        // Growing subtract, the spare mode with the largest step, no step.
        configure(MAG_MAX, 10, MODE_SQRT, RST_DECAY_FACTOR, MAG_W'(20 << FRAC_W));
        queue_column(7, MAG_W'(5000 << FRAC_W), 24'hC0FFEE, 24'h55AA55, 1'b0);
        queue_column(63, MAG_W'(2000 << FRAC_W), 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        configure(MAG_MAX, 3, MODE_SPARE, RST_DECAY_FACTOR, MAG_MAX);
        queue_column(8, MAG_MAX, 24'hFFFFFF, 24'h0F0F0F, 1'b0);
        queue_column(9, MAG_W'((3 << FRAC_W) + 5), 24'h030201, 24'hF0F0F0, 1'b0);
        configure(RST_CLAMP_LEVEL, 200, MODE_LIN, RST_DECAY_FACTOR, 0);
        queue_column(10, MAG_MAX, 24'hA5A5A5, 24'h5A5A5A, 1'b0);
        queue_column(11, 0, 24'hFFFFFF, 24'hFFFFFF, 1'b0);

        // Zero and one LSB ceilings.
        configure(0, 0, MODE_LIN, RST_DECAY_FACTOR, 1);
        queue_column(1, MAG_MAX, 24'hFFFFFF, 24'h102030, 1'b0);
        configure(1, 0, MODE_SQRT, RST_DECAY_FACTOR, 1);
        queue_column(12, MAG_MAX, 24'hFFFFFF, 24'hFFFFFF, 1'b1);

        configure(RST_CLAMP_LEVEL, RST_LOWER_THRESHOLD, MODE_LIN, RST_DECAY_FACTOR,
                  RST_STEP_SIZE);
        run_random(25, 1'b1);
        configure(MAG_MAX, THRESH_W'($urandom), MODE_LOG,
                  DECAY_W'($urandom_range(24000, 32768)), MAG_W'($urandom));
        run_random(25, 1'b0);
        configure(MAG_W'($urandom), THRESH_W'($urandom), MODE_SQRT, DECAY_W'($urandom),
                  MAG_W'($urandom_range(1 << FRAC_W, 200 << FRAC_W)));
        run_random(25, 1'b0);
        configure(MAG_W'($urandom), THRESH_W'($urandom), MODE_SPARE, DECAY_W'($urandom),
                  MAG_W'($urandom));
        run_random(20, 1'b1);
        configure(MAG_W'($urandom), THRESH_W'($urandom), MODE_LOG, DECAY_W'($urandom),
                  MAG_W'($urandom));
        run_random(25, 1'b0);
        configure(MAG_MAX, THRESH_W'($urandom), MODE_LIN, DECAY_W'($urandom),
                  MAG_W'($urandom_range(0, 2000 << FRAC_W)));
        run_random(25, 1'b0);

        wait_idle();
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
